FILE: rtl/core/psh_pkg.sv
// Shared types, sizes and tables for the polar sector histogram.
// No dependencies; every other file of the block but psh_ram uses this package.
package psh_pkg;

  localparam int CoordWidth  = 24;
  localparam int WeightWidth = 16;
  localparam int TotalWidth  = 40;
  localparam int IdxWidth    = 6;
  localparam int CountWidth  = 7;
  localparam int RadWidth    = 23;
  localparam int MaxSectors  = 64;
  localparam int MaxRings    = 64;
  localparam int BinDepth    = MaxSectors * MaxRings;
  localparam int BinAddrW    = $clog2(BinDepth);

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_SECTOR_COUNT = 2'd0,
    CFG_RING_COUNT   = 2'd1,
    CFG_RING_STEP    = 2'd2,
    CFG_INNER_RADIUS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    COR_IDLE, COR_RUN, COR_PHASE, COR_MUL, COR_DONE
  } cor_state_e;

  typedef enum logic [2:0] {
    RAD_IDLE, RAD_SUM, RAD_ROOT, RAD_CMP, RAD_DIV, RAD_FIN, RAD_DONE
  } rad_state_e;

  typedef enum logic [2:0] {
    TOP_CLEAR, TOP_IDLE, TOP_CALC, TOP_READ, TOP_WRITE
  } top_state_e;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      5'd30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/psh_in_if.sv
// Input channel of the polar sector histogram: valid/ready plus one item.
// Depends on psh_pkg for field widths.
interface psh_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [psh_pkg::CoordWidth-1:0] x;
  logic signed [psh_pkg::CoordWidth-1:0] y;
  logic signed [psh_pkg::WeightWidth-1:0] weight;
  logic [psh_pkg::IdxWidth-1:0]          read_sector;
  logic [psh_pkg::IdxWidth-1:0]          read_ring;

  modport source (output valid, op, x, y, weight, read_sector, read_ring, input ready);
  modport sink   (input valid, op, x, y, weight, read_sector, read_ring, output ready);
endinterface

FILE: rtl/core/psh_out_if.sv
// Result channel of the polar sector histogram: valid/ready plus one result.
// Depends on psh_pkg for field widths.
interface psh_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  in_range;
  logic [psh_pkg::IdxWidth-1:0]          sector;
  logic [psh_pkg::IdxWidth-1:0]          ring;
  logic signed [psh_pkg::TotalWidth-1:0] bin_total;

  modport source (output valid, in_range, sector, ring, bin_total, input ready);
  modport sink   (input valid, in_range, sector, ring, bin_total, output ready);
endinterface

FILE: rtl/core/psh_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module psh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/psh_cordic.sv
// Angle unit: iterative CORDIC vectoring, one step per cycle, then sector.
// Depends on psh_pkg (widths, state type, arctangent table).
module psh_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [psh_pkg::CoordWidth-1:0] x_i,
  input  logic signed [psh_pkg::CoordWidth-1:0] y_i,
  input  logic [psh_pkg::CountWidth-1:0]        sectors_i,
  output logic [psh_pkg::IdxWidth-1:0]          sector_o,
  output logic                                  done_o
);
  import psh_pkg::*;

  localparam int VecW = CoordWidth + 20;
  localparam int ZW   = 35;

  cor_state_e state_q, state_d;
  logic signed [VecW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0]   z_q;
  logic [4:0]             it_q;
  logic [32:0]            ph_q;
  logic [IdxWidth-1:0]    sec_q;

  logic                   axis;
  logic signed [VecW-1:0] cx0, cy0, sx, sy;
  logic signed [ZW-1:0]   at, p;
  logic [39:0]            prod;
  logic [7:0]             sec_full;

  // on an axis the phase is exact and no iterations run
  assign axis = (x_i == '0) || (y_i == '0);
  assign cx0  = {{(VecW-CoordWidth-16){x_i[CoordWidth-1]}}, x_i, 16'h0};
  assign cy0  = {{(VecW-CoordWidth-16){y_i[CoordWidth-1]}}, y_i, 16'h0};
  assign sx   = cx_q >>> it_q;
  assign sy   = cy_q >>> it_q;
  assign at   = {{(ZW-30){1'b0}}, atan_turn(it_q)};
  assign p    = z_q + (ZW'(1) <<< 31);
  assign prod = 40'(ph_q) * 40'(sectors_i);
  assign sec_full = prod[39:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= COR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      COR_IDLE, COR_DONE: begin
        if (start_i) state_d = axis ? COR_MUL : COR_RUN;
      end
      COR_RUN:   if (it_q == 5'd31) state_d = COR_PHASE;
      COR_PHASE: state_d = COR_MUL;
      COR_MUL:   state_d = COR_DONE;
      default:   state_d = COR_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      COR_IDLE, COR_DONE: begin
        if (start_i) begin
          it_q <= '0;
          if (y_i == '0) begin
            ph_q <= x_i[CoordWidth-1] ? 33'h1_0000_0000 : 33'h0_8000_0000;
          end else if (x_i == '0) begin
            ph_q <= y_i[CoordWidth-1] ? 33'h0_4000_0000 : 33'h0_C000_0000;
          end else if (x_i[CoordWidth-1]) begin
            // quarter-turn pre-rotation into the right half plane
            if (!y_i[CoordWidth-1]) begin
              cx_q <= cy0;
              cy_q <= -cx0;
              z_q  <= ZW'(1) <<< 30;
            end else begin
              cx_q <= -cy0;
              cy_q <= cx0;
              z_q  <= -(ZW'(1) <<< 30);
            end
          end else begin
            cx_q <= cx0;
            cy_q <= cy0;
            z_q  <= '0;
          end
        end
      end
      COR_RUN: begin
        it_q <= it_q + 5'd1;
        if (cy_q > 0) begin
          cx_q <= cx_q + sy;
          cy_q <= cy_q - sx;
          z_q  <= z_q + at;
        end else if (cy_q < 0) begin
          cx_q <= cx_q - sy;
          cy_q <= cy_q + sx;
          z_q  <= z_q - at;
        end
      end
      COR_PHASE: begin
        // clamp to [0, full turn]
        if (p < 0) ph_q <= '0;
        else if (p > (ZW'(1) <<< 32)) ph_q <= 33'h1_0000_0000;
        else ph_q <= p[32:0];
      end
      COR_MUL: begin
        if (sec_full >= {1'b0, sectors_i}) sec_q <= IdxWidth'(sectors_i - 7'd1);
        else sec_q <= sec_full[IdxWidth-1:0];
      end
      default: ;
    endcase
  end

  assign sector_o = sec_q;
  assign done_o   = (state_q == COR_DONE);
endmodule

FILE: rtl/core/psh_radius.sv
// Radius unit: squares, bit-serial integer square root, then restoring
// division by the ring step. Depends on psh_pkg.
module psh_radius (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [psh_pkg::CoordWidth-1:0] x_i,
  input  logic signed [psh_pkg::CoordWidth-1:0] y_i,
  input  logic [psh_pkg::RadWidth-1:0]          inner_i,
  input  logic [psh_pkg::RadWidth-1:0]          step_i,
  input  logic [psh_pkg::CountWidth-1:0]        rings_i,
  output logic [psh_pkg::IdxWidth-1:0]          ring_o,
  output logic                                  hit_o,
  output logic                                  done_o
);
  import psh_pkg::*;

  localparam int SqW = 2 * CoordWidth;

  rad_state_e state_q, state_d;
  logic [SqW-1:0]        ax2_q, ay2_q, n_q, root_q;
  logic [4:0]            k_q;
  logic [CoordWidth-1:0] d_q, q_q, rem_q;
  logic                  hit_q;

  logic [CoordWidth-1:0] ax, ay, r, rem_sh;
  logic [SqW-1:0]        bitv, trial;
  logic                  below;

  assign ax    = x_i[CoordWidth-1] ? CoordWidth'(-x_i) : CoordWidth'(x_i);
  assign ay    = y_i[CoordWidth-1] ? CoordWidth'(-y_i) : CoordWidth'(y_i);
  assign bitv  = SqW'(1) << (6'(SqW - 2) - {k_q, 1'b0});
  assign trial = root_q + bitv;
  assign r     = root_q[CoordWidth-1:0];
  assign below = r < {1'b0, inner_i};
  assign rem_sh = {rem_q[CoordWidth-2:0], d_q[5'(CoordWidth - 1) - k_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RAD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      RAD_IDLE, RAD_DONE: if (start_i) state_d = RAD_SUM;
      RAD_SUM:  state_d = RAD_ROOT;
      RAD_ROOT: if (k_q == 5'(CoordWidth - 1)) state_d = RAD_CMP;
      RAD_CMP:  state_d = below ? RAD_DONE : RAD_DIV;
      RAD_DIV:  if (k_q == 5'(CoordWidth - 1)) state_d = RAD_FIN;
      RAD_FIN:  state_d = RAD_DONE;
      default:  state_d = RAD_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      RAD_IDLE, RAD_DONE: begin
        if (start_i) begin
          ax2_q <= SqW'(ax) * SqW'(ax);
          ay2_q <= SqW'(ay) * SqW'(ay);
        end
      end
      RAD_SUM: begin
        n_q    <= ax2_q + ay2_q;
        root_q <= '0;
        k_q    <= '0;
      end
      RAD_ROOT: begin
        k_q <= k_q + 5'd1;
        if (n_q >= trial) begin
          n_q    <= n_q - trial;
          root_q <= (root_q >> 1) + bitv;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      RAD_CMP: begin
        hit_q <= 1'b0;
        d_q   <= r - {1'b0, inner_i};
        rem_q <= '0;
        q_q   <= '0;
        k_q   <= '0;
      end
      RAD_DIV: begin
        k_q <= k_q + 5'd1;
        if (rem_sh >= {1'b0, step_i}) begin
          rem_q <= rem_sh - {1'b0, step_i};
          q_q   <= {q_q[CoordWidth-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          q_q   <= {q_q[CoordWidth-2:0], 1'b0};
        end
      end
      RAD_FIN: hit_q <= q_q < CoordWidth'(rings_i);
      default: ;
    endcase
  end

  assign ring_o = q_q[IdxWidth-1:0];
  assign hit_o  = hit_q;
  assign done_o = (state_q == RAD_DONE);
endmodule

FILE: rtl/core/polar_sector_histogram_core.sv
// Polar sector histogram: top level with sequencer, bin store and output register.
// Depends on psh_pkg, psh_in_if, psh_out_if, psh_ram, psh_cordic, psh_radius.
//
// Usage:
//  - in_i carries one item per beat: op 0 adds a weighted point, op 1 reads a bin.
//  - out_o returns exactly one result beat per input beat, in order.
//  - Configuration is to be written through cfg_we_i / cfg_idx_i / cfg_data_i while idle;
//    the block itself does not enforce this. One item is in work at a time. For a binned
//    add the radius path (square, 24-step square root, 24-step division) is the longer;
//    the 32-step angle unit runs alongside. A point beyond the last ring also runs the
//    division; for one inside the inner radius the division is skipped, and the angle
//    unit is then the longer path unless the point lies on an axis. A read skips both units.
//  - Bin update is a read, modify, write on one single-port RAM of 4096 totals.
//  - After reset a clearing pass writes zero to every bin, with in_i.ready low;
//    configuration writes are taken during it.
//  - A result waits in the output register while out_o.ready is low; the next
//    item is still accepted and worked on, and stalls only at its write-back.
module polar_sector_histogram_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  psh_in_if.sink                      in_i,
  psh_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [psh_pkg::RadWidth-1:0] cfg_data_i
);
  import psh_pkg::*;

  top_state_e state_q, state_d;
  logic [BinAddrW-1:0]   clr_q;
  logic [CountWidth-1:0] sc_q, rc_q;
  logic [RadWidth-1:0]   rs_q, ir_q;
  logic                  op_q, hit_q;
  logic signed [WeightWidth-1:0] w_q;
  logic [IdxWidth-1:0]   sec_q, ring_q;
  logic                  ovalid_q, ohit_q;
  logic [IdxWidth-1:0]   osec_q, oring_q;
  logic signed [TotalWidth-1:0] otot_q;

  logic [CountWidth-1:0] sectors, rings;
  logic [RadWidth-1:0]   step;
  logic                  accept, start, slot_free, cor_done, rad_done, rad_hit;
  logic [IdxWidth-1:0]   cor_sec, rad_ring;
  logic                  ram_we, ram_re;
  logic [BinAddrW-1:0]   ram_addr;
  logic [TotalWidth-1:0] ram_wdata, ram_rdata;
  logic signed [TotalWidth:0]   sum;
  logic signed [TotalWidth-1:0] sat, total;

  // effective configuration
  assign sectors = (sc_q == '0) ? 7'd1 : ((sc_q > 7'(MaxSectors)) ? 7'(MaxSectors) : sc_q);
  assign rings   = (rc_q == '0) ? 7'd1 : ((rc_q > 7'(MaxRings)) ? 7'(MaxRings) : rc_q);
  assign step    = (rs_q == '0) ? 23'd1 : rs_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= 7'd64;
      rc_q <= 7'd64;
      rs_q <= 23'd4096;
      ir_q <= 23'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SECTOR_COUNT: sc_q <= cfg_data_i[CountWidth-1:0];
        CFG_RING_COUNT:   rc_q <= cfg_data_i[CountWidth-1:0];
        CFG_RING_STEP:    rs_q <= cfg_data_i;
        CFG_INNER_RADIUS: ir_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready = (state_q == TOP_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign start      = accept && !in_i.op;
  assign slot_free  = !ovalid_q || out_o.ready;

  psh_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(start), .x_i(in_i.x), .y_i(in_i.y),
    .sectors_i(sectors), .sector_o(cor_sec), .done_o(cor_done)
  );

  psh_radius u_radius (
    .clk_i, .rst_ni, .start_i(start), .x_i(in_i.x), .y_i(in_i.y),
    .inner_i(ir_q), .step_i(step), .rings_i(rings),
    .ring_o(rad_ring), .hit_o(rad_hit), .done_o(rad_done)
  );

  psh_ram #(.Width(TotalWidth), .Depth(BinDepth)) u_bins (
    .clk_i, .we_i(ram_we), .re_i(ram_re), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // saturating add of the weight
  assign sum = {ram_rdata[TotalWidth-1], ram_rdata} + (TotalWidth+1)'(w_q);
  always_comb begin
    if (sum[TotalWidth] != sum[TotalWidth-1]) begin
      sat = {sum[TotalWidth], {(TotalWidth-1){~sum[TotalWidth]}}};
    end else begin
      sat = sum[TotalWidth-1:0];
    end
    if (!hit_q) total = '0;
    else if (op_q) total = ram_rdata;
    else total = sat;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TOP_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == TOP_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = {sec_q, ring_q};
    ram_wdata = sat;
    case (state_q)
      TOP_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        if (clr_q == '1) state_d = TOP_IDLE;
      end
      TOP_IDLE: if (accept) state_d = in_i.op ? TOP_READ : TOP_CALC;
      TOP_CALC: if (cor_done && rad_done) state_d = rad_hit ? TOP_READ : TOP_WRITE;
      TOP_READ: begin
        ram_re  = 1'b1;
        state_d = TOP_WRITE;
      end
      TOP_WRITE: begin
        if (slot_free) begin
          ram_we  = hit_q && !op_q;
          state_d = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.op;
      w_q    <= in_i.weight;
      sec_q  <= in_i.read_sector;
      ring_q <= in_i.read_ring;
      hit_q  <= ({1'b0, in_i.read_sector} < sectors) && ({1'b0, in_i.read_ring} < rings);
    end else if (state_q == TOP_CALC && cor_done && rad_done) begin
      sec_q  <= cor_sec;
      ring_q <= rad_hit ? rad_ring : '0;
      hit_q  <= rad_hit;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == TOP_WRITE && slot_free) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == TOP_WRITE && slot_free) begin
      ohit_q  <= hit_q;
      osec_q  <= sec_q;
      oring_q <= ring_q;
      otot_q  <= total;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.in_range  = ohit_q;
  assign out_o.sector    = osec_q;
  assign out_o.ring      = oring_q;
  assign out_o.bin_total = otot_q;

  // checks
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == TOP_CLEAR || state_q == TOP_WRITE))
    else $error("bin write outside clear or write-back");

  a_hit_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TOP_WRITE && hit_q) |-> ({1'b0, ring_q} < rings && {1'b0, sec_q} < sectors))
    else $error("bin index outside counts");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TOP_WRITE && hit_q && !op_q && slot_free) |-> $past(ram_re) || $past(state_q == TOP_WRITE))
    else $error("bin update without a read of the bin");

  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TOP_CLEAR) |-> !ovalid_q)
    else $error("result during clearing pass");
endmodule
